// File: rtl/bfha_pkg.sv
`default_nettype none
package bfha_pkg;

    // Sizing defaults
    localparam int unsigned MAX_BLOCKS   = 32;
    localparam int unsigned HEAP_BYTES   = 65536;
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned ALIGN_BYTES  = 8;   // power of two

    // Usable heap ceiling: limited by HEAP_BYTES and by the 16-bit offsets
    localparam int unsigned HEAP_LIMIT = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;

    // Action codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_INIT  = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_ADDR  = 3'd3,
        ST_TOO_SMALL = 3'd4
    } t_status;

    // One block table entry
    typedef struct packed {
        logic [15:0] start;
        logic [16:0] size;
        logic        used;
    } t_entry;

endpackage
`default_nettype wire

// File: rtl/bfha_table.sv
`default_nettype none
// Block table: one write port, one read port, registered read data.
module bfha_table #(
    parameter int unsigned DEPTH = bfha_pkg::MAX_BLOCKS,
    parameter int unsigned IW    = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [IW-1:0]   i_waddr,
    input  wire bfha_pkg::t_entry i_wdata,
    input  wire logic            i_re,
    input  wire logic [IW-1:0]   i_raddr,
    output bfha_pkg::t_entry     o_rdata
);

    bfha_pkg::t_entry r_mem [DEPTH];
    bfha_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data, held while i_re is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/best_fit_heap_allocator_unit.sv
`default_nettype none
// Best-fit heap allocator with coalescing on free.
// Requests: start is sampled with i_action, i_req_size and i_address; a request
// is taken at a clock edge where start is high and busy is low. busy stays high
// while the request works through the block table.
// Results: one per request, on o_status, o_alloc_address and o_peak_used for a
// single cycle marked by o_valid. The receiver cannot stall; busy is already low
// in the result cycle, so the next request may be taken there.
// Configuration: i_heap_size_we loads i_heap_size for the next initialize; the user
// must do so only while no request is in flight; the block does not enforce it.
// Flow: initialize, unused codes and requests on an uninitialized heap are
// answered from idle. Allocate scans all live blocks, then, if one fits and the
// table has room, moves each entry after the chosen block up to open a slot.
// Free scans up to the matching used block, then moves the later entries down
// after a merge. Each move reads an entry and then writes it to its new place.
// Reset: the heap is uninitialized (allocate answers no fit, free answers
// unknown address), the peak is zero and heap_size returns to its default.
// The table needs no clearing: only the first block-count entries are read.
module best_fit_heap_allocator_unit #(
    parameter int unsigned MAX_BLOCKS = bfha_pkg::MAX_BLOCKS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_heap_size_we,
    input  wire logic [16:0] i_heap_size,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_req_size,
    input  wire logic [15:0] i_address,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [15:0]      o_alloc_address,
    output logic [16:0]      o_peak_used
);

    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned SW = CW + 1;
    localparam logic [16:0] HDR    = 17'(bfha_pkg::HEADER_BYTES);
    localparam logic [16:0] AMASK  = 17'(bfha_pkg::ALIGN_BYTES - 1);
    localparam logic [16:0] LIMIT  = 17'(bfha_pkg::HEAP_LIMIT);
    localparam logic [CW-1:0] FULL = CW'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_ADEC, S_FRD, S_FGET, S_SHRD, S_SHWR, S_AFIN
    } t_state;

    t_state           r_state;
    logic             r_busy;
    logic             r_valid;
    bfha_pkg::t_status r_status;
    logic [15:0]      r_aout;
    logic [16:0]      r_heap;
    logic [16:0]      r_peak;
    logic [16:0]      r_total;
    logic [CW-1:0]    r_count;
    logic [1:0]       r_action;
    logic [16:0]      r_aligned;
    logic [17:0]      r_need;
    logic [15:0]      r_addr;
    logic [CW-1:0]    r_iss;
    logic [IW-1:0]    r_kd;
    logic             r_dv;
    logic             r_found;
    logic [IW-1:0]    r_best;
    logic [16:0]      r_best_size;
    logic [15:0]      r_best_start;
    logic [IW-1:0]    r_idx;
    bfha_pkg::t_entry r_cur;
    bfha_pkg::t_entry r_prev;
    logic             r_nx_ok;
    logic [SW-1:0]    r_src;
    logic [1:0]       r_d;
    logic             r_up;
    logic [15:0]      r_ns;

    logic             accept;
    logic [16:0]      req_nz;
    logic [16:0]      aligned;
    logic [16:0]      lim;
    logic             scan_last;
    logic             shift_go;
    logic [SW-1:0]    dst;
    logic [16:0]      best_rem;
    logic [16:0]      new_total;
    logic             nxt_free;
    logic             prv_free;
    logic [IW-1:0]    f_waddr;
    bfha_pkg::t_entry f_wdata;
    logic [SW-1:0]    f_s0;
    logic [1:0]       f_d;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    bfha_pkg::t_entry mem_wdata;
    logic             mem_re;
    logic [IW-1:0]    mem_raddr;
    bfha_pkg::t_entry rd;

    bfha_table #(
        .DEPTH (MAX_BLOCKS),
        .IW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    // request decode
    assign accept  = start && !r_busy;
    assign req_nz  = (i_req_size == 16'd0) ? 17'd1 : {1'b0, i_req_size};
    assign aligned = (req_nz + AMASK) & ~AMASK;
    assign lim     = (r_heap > LIMIT) ? LIMIT : r_heap;

    // scan / shift helpers
    assign scan_last = ({{(CW-IW){1'b0}}, r_kd} == (r_count - CW'(1)));
    assign shift_go  = r_up ? (r_src > SW'(r_best)) : (r_src < SW'(r_count));
    assign dst       = r_up ? (r_src + SW'(1)) : (r_src - SW'(r_d));
    assign best_rem  = 17'({1'b0, r_best_size} - r_need);
    assign new_total = r_total + r_aligned;

    // merge plan for free
    assign nxt_free = r_nx_ok && !rd.used;
    assign prv_free = (r_idx != '0) && !r_prev.used;

    always_comb begin
        f_waddr = r_idx;
        f_wdata = '{start: r_cur.start, size: r_cur.size, used: 1'b0};
        f_s0    = SW'(r_count);
        f_d     = 2'd0;
        case ({prv_free, nxt_free})
            2'b11: begin
                f_waddr = r_idx - IW'(1);
                f_wdata = '{start: r_prev.start,
                            size: r_prev.size + r_cur.size + rd.size + HDR + HDR,
                            used: 1'b0};
                f_s0    = SW'(r_idx) + SW'(2);
                f_d     = 2'd2;
            end
            2'b10: begin
                f_waddr = r_idx - IW'(1);
                f_wdata = '{start: r_prev.start, size: r_prev.size + r_cur.size + HDR,
                            used: 1'b0};
                f_s0    = SW'(r_idx) + SW'(1);
                f_d     = 2'd1;
            end
            2'b01: begin
                f_wdata = '{start: r_cur.start, size: r_cur.size + rd.size + HDR,
                            used: 1'b0};
                f_s0    = SW'(r_idx) + SW'(2);
                f_d     = 2'd1;
            end
            default: ;
        endcase
    end

    // table port steering; reads and writes never hit the same entry in one cycle
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = f_wdata;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                mem_we    = accept && (i_action == bfha_pkg::ACT_INIT) && (lim > HDR);
                mem_wdata = '{start: 16'd0, size: lim - HDR, used: 1'b0};
            end
            S_SCAN: begin
                mem_re    = (r_iss < r_count);
                mem_raddr = r_iss[IW-1:0];
            end
            S_ADEC: begin
                mem_we    = r_found && (r_count != FULL);
                mem_waddr = r_best;
                mem_wdata = '{start: r_best_start, size: best_rem, used: 1'b0};
            end
            S_FRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx + IW'(1);
            end
            S_FGET: begin
                mem_we    = 1'b1;
                mem_waddr = f_waddr;
            end
            S_SHRD: begin
                mem_re    = shift_go;
                mem_raddr = r_src[IW-1:0];
            end
            S_SHWR: begin
                mem_we    = 1'b1;
                mem_waddr = dst[IW-1:0];
                mem_wdata = rd;
            end
            S_AFIN: begin
                mem_we    = 1'b1;
                mem_waddr = r_best + IW'(1);
                mem_wdata = '{start: r_ns, size: r_aligned, used: 1'b1};
            end
            default: ;
        endcase
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_status <= bfha_pkg::ST_OK;
            r_aout  <= '0;
            r_heap  <= 17'h10000;
            r_peak  <= '0;
            r_total <= '0;
            r_count <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_heap_size_we) begin
                r_heap <= i_heap_size;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_action  <= i_action;
                        r_aligned <= aligned;
                        r_need    <= {1'b0, aligned} + {1'b0, HDR};
                        r_addr    <= i_address;
                        r_iss     <= '0;
                        r_dv      <= 1'b0;
                        r_found   <= 1'b0;
                        r_aout    <= '0;
                        case (i_action)
                            bfha_pkg::ACT_ALLOC, bfha_pkg::ACT_FREE: begin
                                if (r_count == '0) begin
                                    r_valid  <= 1'b1;
                                    r_status <= (i_action == bfha_pkg::ACT_ALLOC) ?
                                                bfha_pkg::ST_NO_FIT : bfha_pkg::ST_BAD_ADDR;
                                end else begin
                                    r_busy  <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            bfha_pkg::ACT_INIT: begin
                                r_valid <= 1'b1;
                                if (lim > HDR) begin
                                    r_status <= bfha_pkg::ST_OK;
                                    r_count  <= CW'(1);
                                    r_peak   <= '0;
                                    r_total  <= '0;
                                end else begin
                                    r_status <= bfha_pkg::ST_TOO_SMALL;
                                end
                            end
                            default: begin
                                r_valid  <= 1'b1;
                                r_status <= bfha_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_iss < r_count) begin
                        r_iss <= r_iss + CW'(1);
                    end
                    r_dv <= (r_iss < r_count);
                    r_kd <= r_iss[IW-1:0];
                    if (r_dv) begin
                        if (r_action == bfha_pkg::ACT_ALLOC) begin
                            // best fit, ties go to the later block
                            if (!rd.used && ({1'b0, rd.size} >= r_need) &&
                                (!r_found || rd.size <= r_best_size)) begin
                                r_found      <= 1'b1;
                                r_best       <= r_kd;
                                r_best_size  <= rd.size;
                                r_best_start <= rd.start;
                            end
                            if (scan_last) begin
                                r_state <= S_ADEC;
                            end
                        end else begin
                            // first used block whose payload offset matches
                            if (rd.used && ((17'(rd.start) + HDR) == {1'b0, r_addr})) begin
                                r_idx   <= r_kd;
                                r_cur   <= rd;
                                r_nx_ok <= !scan_last;
                                r_state <= scan_last ? S_FGET : S_FRD;
                            end else begin
                                r_prev <= rd;
                                if (scan_last) begin
                                    r_valid  <= 1'b1;
                                    r_status <= bfha_pkg::ST_BAD_ADDR;
                                    r_busy   <= 1'b0;
                                    r_state  <= S_IDLE;
                                end
                            end
                        end
                    end
                end
                S_ADEC: begin
                    if (!r_found || (r_count == FULL)) begin
                        r_valid  <= 1'b1;
                        r_status <= r_found ? bfha_pkg::ST_FULL : bfha_pkg::ST_NO_FIT;
                        r_busy   <= 1'b0;
                        r_state  <= S_IDLE;
                    end else begin
                        // tail of the chosen block becomes the new used block
                        r_ns    <= 16'(17'(r_best_start) + HDR + best_rem);
                        r_src   <= SW'(r_count) - SW'(1);
                        r_up    <= 1'b1;
                        r_state <= S_SHRD;
                    end
                end
                S_FRD: begin
                    r_state <= S_FGET;
                end
                S_FGET: begin
                    r_src   <= f_s0;
                    r_d     <= f_d;
                    r_up    <= 1'b0;
                    r_state <= S_SHRD;
                end
                S_SHRD: begin
                    if (shift_go) begin
                        r_state <= S_SHWR;
                    end else if (r_action == bfha_pkg::ACT_ALLOC) begin
                        r_state <= S_AFIN;
                    end else begin
                        r_count  <= r_count - CW'(r_d);
                        r_total  <= r_total - r_cur.size;
                        r_valid  <= 1'b1;
                        r_status <= bfha_pkg::ST_OK;
                        r_busy   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_SHWR: begin
                    r_src   <= r_up ? (r_src - SW'(1)) : (r_src + SW'(1));
                    r_state <= S_SHRD;
                end
                S_AFIN: begin
                    r_count  <= r_count + CW'(1);
                    r_total  <= new_total;
                    if (new_total > r_peak) begin
                        r_peak <= new_total;
                    end
                    r_aout   <= r_ns + 16'(bfha_pkg::HEADER_BYTES);
                    r_valid  <= 1'b1;
                    r_status <= bfha_pkg::ST_OK;
                    r_busy   <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy            = r_busy;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_alloc_address = r_aout;
    assign o_peak_used     = r_peak;

endmodule
`default_nettype wire

// File: rtl/bfha_checker.sv
`default_nettype none
// Port-level checks for the allocator.
module bfha_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [2:0]  o_status,
    input wire logic [15:0] o_alloc_address
);

    // a taken request is either answered next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("request neither answered nor busy");

    // a result never shows while the block is still busy
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");

    // leaving busy always delivers the result
    a_fell_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without result");

    // failed requests report no address
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != bfha_pkg::ST_OK)) |-> (o_alloc_address == 16'd0))
        else $error("address on failed request");

    // reset leaves the block idle with no result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("not idle after reset");

endmodule

bind best_fit_heap_allocator_unit bfha_checker u_bfha_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_status        (o_status),
    .o_alloc_address (o_alloc_address)
);
`default_nettype wire

// File: tb/best_fit_heap_allocator_unit_test.sv
`timescale 1ns / 1ps
`default_nettype none
module best_fit_heap_allocator_unit_test;

    localparam int unsigned NBLK = bfha_pkg::MAX_BLOCKS;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // One request to the allocator
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] req_size;
        logic [15:0] address;
    } t_req;

    // One answer from the allocator
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] alloc_address;
        logic [16:0] peak_used;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_heap_size_we = 1'b0;
    logic [16:0] i_heap_size = 17'd0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_action = bfha_pkg::ACT_ALLOC;
    logic [15:0] i_req_size = 16'd0;
    logic [15:0] i_address = 16'd0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [15:0] o_alloc_address;
    logic [16:0] o_peak_used;

    best_fit_heap_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_heap_size_we(i_heap_size_we), .i_heap_size(i_heap_size),
        .start(start), .busy(busy),
        .i_action(i_action), .i_req_size(i_req_size), .i_address(i_address),
        .o_valid(o_valid), .o_status(o_status),
        .o_alloc_address(o_alloc_address), .o_peak_used(o_peak_used)
    );

    always #10 i_clk = ~i_clk;

    // Shadow of the allocator state
    logic [15:0] sh_start [NBLK];
    logic [16:0] sh_size [NBLK];
    logic        sh_used [NBLK];
    int unsigned sh_count;
    logic [16:0] sh_peak;
    logic [16:0] sh_heap_size;

    t_req        pending_reqs [$];
    t_answer     expected_answers [$];
    logic [15:0] live_addrs [$];     // payload offsets handed out and not yet freed
    int unsigned mismatches = 0;
    int unsigned answers_seen = 0;
    int unsigned allocs_ok = 0, frees_ok = 0, full_hits = 0, nofit_hits = 0;
    logic        timed_out = 1'b0;
    logic        took_req = 1'b0;
    int unsigned idle_cycles = 0;

    function automatic void drop_entry(input int unsigned idx);
        for (int unsigned k = idx; k + 1 < sh_count; k++) begin
            sh_start[k] = sh_start[k + 1];
            sh_size[k]  = sh_size[k + 1];
            sh_used[k]  = sh_used[k + 1];
        end
        sh_count--;
    endfunction

    // Work out the answer to one request and advance the shadow state
    function automatic t_answer predict_answer(input t_req r);
        t_answer a;
        int unsigned total, aligned, need, best, best_sz, ns, sum, idx, rq;
        bit found;
        int hit [$];
        a = '0;
        case (r.action)
            bfha_pkg::ACT_INIT: begin
                total = sh_heap_size;
                if (total > bfha_pkg::HEAP_LIMIT) total = bfha_pkg::HEAP_LIMIT;
                if (total <= bfha_pkg::HEADER_BYTES) a.status = bfha_pkg::ST_TOO_SMALL;
                else begin
                    sh_start[0] = '0;
                    sh_size[0] = 17'(total - bfha_pkg::HEADER_BYTES);
                    sh_used[0] = 1'b0;
                    sh_count = 1;
                    sh_peak = '0;
                    live_addrs.delete();
                end
            end
            bfha_pkg::ACT_ALLOC: begin
                if (sh_count == 0) a.status = bfha_pkg::ST_NO_FIT;
                else begin
                    rq = (r.req_size == 0) ? 1 : r.req_size;
                    aligned = ((rq + bfha_pkg::ALIGN_BYTES - 1) / bfha_pkg::ALIGN_BYTES)
                              * bfha_pkg::ALIGN_BYTES;
                    need = aligned + bfha_pkg::HEADER_BYTES;
                    found = 0; best = 0; best_sz = 0;
                    for (int unsigned k = 0; k < sh_count; k++) begin
                        if (!sh_used[k] && sh_size[k] >= need
                                && (!found || sh_size[k] <= best_sz)) begin
                            found = 1; best = k; best_sz = sh_size[k];
                        end
                    end
                    if (!found) a.status = bfha_pkg::ST_NO_FIT;
                    else if (sh_count >= NBLK) a.status = bfha_pkg::ST_FULL;
                    else begin
                        sh_size[best] = sh_size[best] - 17'(need);
                        ns = sh_start[best] + bfha_pkg::HEADER_BYTES + sh_size[best];
                        for (int unsigned k = sh_count; k > best + 1; k--) begin
                            sh_start[k] = sh_start[k - 1];
                            sh_size[k]  = sh_size[k - 1];
                            sh_used[k]  = sh_used[k - 1];
                        end
                        sh_start[best + 1] = 16'(ns);
                        sh_size[best + 1] = 17'(aligned);
                        sh_used[best + 1] = 1'b1;
                        sh_count++;
                        sum = 0;
                        for (int unsigned k = 0; k < sh_count; k++)
                            if (sh_used[k]) sum += sh_size[k];
                        if (sum > sh_peak) sh_peak = 17'(sum);
                        a.alloc_address = 16'(ns + bfha_pkg::HEADER_BYTES);
                        live_addrs.push_back(a.alloc_address);
                    end
                end
            end
            bfha_pkg::ACT_FREE: begin
                found = 0; idx = 0;
                for (int unsigned k = 0; k < sh_count; k++) begin
                    if (!found && sh_used[k]
                            && sh_start[k] + bfha_pkg::HEADER_BYTES == r.address) begin
                        idx = k; found = 1;
                    end
                end
                if (!found) a.status = bfha_pkg::ST_BAD_ADDR;
                else begin
                    sh_used[idx] = 1'b0;
                    if (idx + 1 < sh_count && !sh_used[idx + 1]) begin
                        sh_size[idx] = 17'(sh_size[idx] + sh_size[idx + 1]
                                           + bfha_pkg::HEADER_BYTES);
                        drop_entry(idx + 1);
                    end
                    if (idx > 0 && !sh_used[idx - 1]) begin
                        sh_size[idx - 1] = 17'(sh_size[idx - 1] + sh_size[idx]
                                               + bfha_pkg::HEADER_BYTES);
                        drop_entry(idx);
                    end
                    hit = live_addrs.find_first_index(x) with (x == r.address);
                    if (hit.size() > 0) live_addrs.delete(hit[0]);
                end
            end
            default: ;
        endcase
        a.peak_used = sh_peak;
        return a;
    endfunction

    // Driver: bursts of back-to-back requests with random gaps
    int unsigned burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!start || took_req) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    t_req r;
                    r = pending_reqs.pop_front();
                    i_action <= r.action;
                    i_req_size <= r.req_size;
                    i_address <= r.address;
                    start <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
                    end else burst_left--;
                end else start <= 1'b0;
            end
        end
    end

    // Acceptance tracking and prediction at the rising edge
    always @(posedge i_clk) begin
        took_req <= 1'b0;
        if (i_rst_n && start && !busy) begin
            t_req r;
            r = '{action: i_action, req_size: i_req_size, address: i_address};
            expected_answers.push_back(predict_answer(r));
            took_req <= 1'b1;
        end
        if (i_rst_n && ((start && !busy) || o_valid))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
    end

    // Monitor: compare each answer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_answer want;
            answers_seen++;
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer status=%0d addr=%0d peak=%0d",
                             o_status, o_alloc_address, o_peak_used);
            end else begin
                want = expected_answers.pop_front();
                if (o_status !== want.status || o_alloc_address !== want.alloc_address
                        || o_peak_used !== want.peak_used) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want st=%0d addr=%0d peak=%0d",
                                  " got st=%0d addr=%0d peak=%0d"},
                                 want.status, want.alloc_address, want.peak_used,
                                 o_status, o_alloc_address, o_peak_used);
                end else if (want.status == bfha_pkg::ST_OK && o_alloc_address != 0)
                    allocs_ok++;
                else if (want.status == bfha_pkg::ST_FULL) full_hits++;
                else if (want.status == bfha_pkg::ST_NO_FIT) nofit_hits++;
            end
        end
    end

    // Watchdog on cycles with no progress
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d answers outstanding",
                     expected_answers.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_req mk(input logic [1:0] act, input logic [15:0] sz,
                                input logic [15:0] adr);
        t_req r;
        r.action = act; r.req_size = sz; r.address = adr;
        return r;
    endfunction

    // Pick a mostly plausible random request
    function automatic t_req random_req();
        int unsigned pick;
        logic [15:0] sz;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            case ($urandom_range(0, 9))
                0: sz = 16'($urandom);
                1: sz = 16'($urandom_range(0, 8));
                default: sz = 16'($urandom_range(0, 3000));
            endcase
            return mk(bfha_pkg::ACT_ALLOC, sz, 16'($urandom));
        end else if (pick < 88 && live_addrs.size() > 0)
            return mk(bfha_pkg::ACT_FREE, 16'($urandom),
                      live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
        else if (pick < 94)
            return mk(bfha_pkg::ACT_FREE, 16'($urandom), 16'($urandom));
        else if (pick < 97)
            return mk(ACT_SPARE, 16'($urandom), 16'($urandom));
        else
            return mk(bfha_pkg::ACT_INIT, 16'($urandom), 16'($urandom));
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_answers.size() > 0 || start)
            @(posedge i_clk);
        repeat (3 * NBLK + 10) @(posedge i_clk);
    endtask

    task automatic write_heap_size(input logic [16:0] v);
        @(negedge i_clk);
        i_heap_size <= v;
        i_heap_size_we <= 1'b1;
        sh_heap_size = v;
        @(negedge i_clk);
        i_heap_size_we <= 1'b0;
    endtask

    // Random phase: the predictor runs at acceptance, so frees of live
    // addresses are chosen just before each request is queued
    task automatic run_random(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            while (pending_reqs.size() > 0 || expected_answers.size() > 2)
                @(posedge i_clk);
            pending_reqs.push_back(random_req());
        end
        wait_drained();
    endtask

    initial begin
        logic [16:0] sizes [6];
        sizes = '{17'd65536, 17'd0, 17'd16, 17'd17, 17'd1024, 17'h1FFFF};
        for (int i = 0; i < NBLK; i++) begin
            sh_start[i] = '0; sh_size[i] = '0; sh_used[i] = 1'b0;
        end
        sh_count = 0; sh_peak = '0; sh_heap_size = 17'd65536;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: before init, then extremes of the fields
        pending_reqs.push_back(mk(bfha_pkg::ACT_ALLOC, 16'd0, 16'd0));
        pending_reqs.push_back(mk(bfha_pkg::ACT_FREE, 16'd0, 16'hFFFF));
        pending_reqs.push_back(mk(ACT_SPARE, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(mk(bfha_pkg::ACT_INIT, 16'd0, 16'd0));
        pending_reqs.push_back(mk(bfha_pkg::ACT_ALLOC, 16'd0, 16'd0));
        pending_reqs.push_back(mk(bfha_pkg::ACT_ALLOC, 16'd8, 16'd0));
        pending_reqs.push_back(mk(bfha_pkg::ACT_ALLOC, 16'd9, 16'd0));
        pending_reqs.push_back(mk(bfha_pkg::ACT_ALLOC, 16'hFFFF, 16'd0));
        pending_reqs.push_back(mk(bfha_pkg::ACT_ALLOC, 16'd65000, 16'd0));
        pending_reqs.push_back(mk(bfha_pkg::ACT_FREE, 16'd0, 16'd0));
        wait_drained();
        // Request NBLK + 1 small allocations, then free all live blocks with merging
        for (int i = 0; i < NBLK + 1; i++)
            pending_reqs.push_back(mk(bfha_pkg::ACT_ALLOC, 16'(1 + i), 16'd0));
        wait_drained();
        while (live_addrs.size() > 0) begin
            pending_reqs.push_back(mk(bfha_pkg::ACT_FREE, 16'd0,
                                      live_addrs[$urandom_range(0, live_addrs.size() - 1)]));
            wait_drained();
        end
        pending_reqs.push_back(mk(bfha_pkg::ACT_FREE, 16'd0, 16'd16));
        wait_drained();

        // Random phases over several heap sizes, extremes included
        foreach (sizes[s]) begin
            write_heap_size(sizes[s]);
            pending_reqs.push_back(mk(bfha_pkg::ACT_INIT, 16'd0, 16'd0));
            run_random(250);
        end
        write_heap_size(17'($urandom_range(200, 65536)));
        pending_reqs.push_back(mk(bfha_pkg::ACT_INIT, 16'd0, 16'd0));
        run_random(300);

        $display("run covered %0d answers: %0d allocations, %0d no-fit, %0d table-full",
                 answers_seen, allocs_ok, nofit_hits, full_hits);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("RESULT: OK");
        else begin
            $display("%0d mismatches, %0d answers missing", mismatches,
                     expected_answers.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
